[sv/iec61937_burst_sync_parser_defines.svh]
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, reset by i_rst_n.
// ---------------------------------------------------------------------------
`ifndef IEC61937_BURST_SYNC_PARSER_DEFINES_SVH
`define IEC61937_BURST_SYNC_PARSER_DEFINES_SVH

// Same-cycle implication.
`define IBSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IBSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ibsp_pkg.sv]
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - package
// Shared constants, codes and types of the parser front end, queue and
// output stage.
// ---------------------------------------------------------------------------
package ibsp_pkg;

    localparam int GUARD_WORDS     = 4;
    localparam int BYTE_DEPTH      = 2 * GUARD_WORDS + 1;
    localparam int WORD_HIST_DEPTH = (GUARD_WORDS > 0) ? GUARD_WORDS : 1;
    localparam int HIST_CNT_W      = $clog2(BYTE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int SAMPLE_W     = 32;
    localparam int WORD_W       = 16;
    localparam int TYPE_W       = 5;
    localparam int SUBFRAME_LSB = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WORD_W-1:0] SYNC_A_RESET     = 16'hF872;
    localparam logic [WORD_W-1:0] SYNC_B_RESET     = 16'h4E1F;
    localparam logic [TYPE_W-1:0] BYTES_TYPE_RESET = 5'd21;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_PB   = 3'd1,
        PH_PC   = 3'd2,
        PH_PD   = 3'd3,
        PH_PAY  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER      = 2'd0,
        KIND_PAYLOAD     = 2'd1,
        KIND_GUARD_ERR   = 2'd2,
        KIND_PB_MISMATCH = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAM_MODE    = 2'd0,
        CFG_SYNC_WORD_A    = 2'd1,
        CFG_SYNC_WORD_B    = 2'd2,
        CFG_BYTES_LEN_TYPE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              stream_mode;
        logic [WORD_W-1:0] sync_word_a;
        logic [WORD_W-1:0] sync_word_b;
        logic [TYPE_W-1:0] bytes_len_type;
    } t_cfg;

    // Compact result: value is the length on headers, the raw word on payload.
    typedef struct packed {
        t_kind             kind;
        logic [TYPE_W-1:0] data_type;
        logic [WORD_W-1:0] value;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_queue_head;

endpackage

[sv/ibsp_front.sv]
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - front end
// Builds 16-bit words from bytes or subframes, runs the burst preamble
// state machine and classifies each item into at most one result.
// ---------------------------------------------------------------------------
`include "iec61937_burst_sync_parser_defines.svh"

module ibsp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ibsp_pkg::t_cfg                   i_cfg,
    input  logic                             i_mode_wr,
    input  logic                             i_accept,
    input  logic [ibsp_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_push,
    output ibsp_pkg::t_result                o_result
);
    import ibsp_pkg::*;

    t_phase                r_phase, n_phase;
    logic [HIST_CNT_W-1:0] r_hist_cnt, n_hist_cnt;
    logic                  r_parity, n_parity;
    logic [TYPE_W-1:0]     r_burst_type, n_burst_type;
    logic [WORD_W-1:0]     r_remaining, n_remaining;
    logic [7:0]            r_byte_hist [BYTE_DEPTH];
    logic [WORD_W-1:0]     r_word_hist [WORD_HIST_DEPTH];

    logic              w_byte_mode;
    logic [7:0]        w_byte;
    logic [WORD_W-1:0] w_word;
    logic              w_have;
    logic              w_guard_ok;
    logic              w_sync_a;
    logic              w_sync_b;
    logic [WORD_W-1:0] w_len;
    logic              w_len_zero;
    logic              w_last;

    assign w_byte_mode = ~i_cfg.stream_mode;
    assign w_byte      = i_sample[7:0];

    // Word assembly: byte pairs little-endian, or the subframe audio field.
    always_comb begin : word_build
        if (w_byte_mode) begin
            w_word = {w_byte, r_byte_hist[0]};
            w_have = (r_phase == PH_HUNT) ? (r_hist_cnt != '0) : r_parity;
        end else begin
            w_word = i_sample[SUBFRAME_LSB +: WORD_W];
            w_have = 1'b1;
        end
    end

    // Guard check over the whole words seen before Pa.
    always_comb begin : guard_check
        w_guard_ok = 1'b1;
        if (w_byte_mode) begin
            for (int k = 1; k <= GUARD_WORDS; k++) begin
                if ((r_hist_cnt >= HIST_CNT_W'(2 * k + 1)) &&
                    ((r_byte_hist[2 * k] != 8'd0) || (r_byte_hist[2 * k - 1] != 8'd0))) begin
                    w_guard_ok = 1'b0;
                end
            end
        end else begin
            for (int k = 0; k < GUARD_WORDS; k++) begin
                if ((r_hist_cnt > HIST_CNT_W'(k)) && (r_word_hist[k] != '0)) begin
                    w_guard_ok = 1'b0;
                end
            end
        end
    end

    assign w_sync_a   = (w_word == i_cfg.sync_word_a);
    assign w_sync_b   = (w_word == i_cfg.sync_word_b);
    assign w_len      = (r_burst_type == i_cfg.bytes_len_type) ? w_word
                                                               : {3'd0, w_word[WORD_W-1:3]};
    assign w_len_zero = (w_len == '0);
    assign w_last     = (r_remaining <= WORD_W'(2));

    // Next phase.
    always_comb begin : fsm_next
        n_phase = r_phase;
        if (i_mode_wr) begin
            n_phase = PH_HUNT;
        end else if (i_accept && w_have) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_sync_a && w_guard_ok) begin
                        n_phase = PH_PB;
                    end
                end
                PH_PB:  n_phase = w_sync_b ? PH_PC : PH_HUNT;
                PH_PC:  n_phase = PH_PD;
                PH_PD:  n_phase = w_len_zero ? PH_HUNT : PH_PAY;
                PH_PAY: begin
                    if (w_last) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // Results and side state.
    always_comb begin : fsm_out
        o_push       = 1'b0;
        o_result     = '{kind: KIND_HEADER, data_type: '0, value: '0, last: 1'b0};
        n_parity     = r_parity;
        n_hist_cnt   = r_hist_cnt;
        n_burst_type = r_burst_type;
        n_remaining  = r_remaining;
        if (i_mode_wr) begin
            n_parity   = 1'b0;
            n_hist_cnt = '0;
        end else if (i_accept) begin
            if (w_byte_mode && (r_phase != PH_HUNT)) begin
                n_parity = ~r_parity;
            end
            if (w_byte_mode) begin
                if (r_hist_cnt < HIST_CNT_W'(BYTE_DEPTH)) begin
                    n_hist_cnt = r_hist_cnt + HIST_CNT_W'(1);
                end
            end else if (r_hist_cnt < HIST_CNT_W'(GUARD_WORDS)) begin
                n_hist_cnt = r_hist_cnt + HIST_CNT_W'(1);
            end
            if (w_have) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (w_sync_a) begin
                            if (w_guard_ok) begin
                                n_parity = 1'b0;
                            end else begin
                                o_push        = 1'b1;
                                o_result.kind = KIND_GUARD_ERR;
                            end
                        end
                    end
                    PH_PB: begin
                        if (!w_sync_b) begin
                            // In byte mode the high byte of the rejected Pb opens the next word.
                            o_push        = 1'b1;
                            o_result.kind = KIND_PB_MISMATCH;
                            n_parity      = 1'b0;
                            n_hist_cnt    = w_byte_mode ? HIST_CNT_W'(1) : '0;
                        end
                    end
                    PH_PC: n_burst_type = w_word[TYPE_W-1:0];
                    PH_PD: begin
                        o_push             = 1'b1;
                        o_result.kind      = KIND_HEADER;
                        o_result.data_type = r_burst_type;
                        o_result.value     = w_len;
                        if (w_len_zero) begin
                            n_parity   = 1'b0;
                            n_hist_cnt = '0;
                        end else begin
                            n_remaining = w_len;
                        end
                    end
                    PH_PAY: begin
                        o_push             = 1'b1;
                        o_result.kind      = KIND_PAYLOAD;
                        o_result.data_type = r_burst_type;
                        o_result.value     = w_word;
                        o_result.last      = w_last;
                        n_remaining        = w_last ? '0 : r_remaining - WORD_W'(2);
                        if (w_last) begin
                            n_parity   = 1'b0;
                            n_hist_cnt = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_hist_cnt <= '0;
            r_parity   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hist_cnt <= n_hist_cnt;
            r_parity   <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst_type <= n_burst_type;
        r_remaining  <= n_remaining;
        if (i_accept && w_byte_mode) begin
            r_byte_hist[0] <= w_byte;
            for (int i = 1; i < BYTE_DEPTH; i++) begin
                r_byte_hist[i] <= r_byte_hist[i-1];
            end
        end
        if (i_accept && !w_byte_mode) begin
            r_word_hist[0] <= w_word;
            for (int i = 1; i < WORD_HIST_DEPTH; i++) begin
                r_word_hist[i] <= r_word_hist[i-1];
            end
        end
    end

    `IBSP_ASSERT_NXT(a_mode_wr_hunts, i_mode_wr, r_phase == PH_HUNT, "mode write did not return to hunting")
    `IBSP_ASSERT_IMP(a_pay_nonzero, r_phase == PH_PAY, r_remaining != '0, "payload phase with zero length left")
    `IBSP_ASSERT_IMP(a_payload_src, o_push && (o_result.kind == KIND_PAYLOAD), r_phase == PH_PAY, "payload result outside payload phase")
    `IBSP_ASSERT_IMP(a_hist_bound, 1'b1, r_hist_cnt <= HIST_CNT_W'(BYTE_DEPTH), "history count overflow")

endmodule

[sv/ibsp_queue.sv]
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - result queue
// Small FIFO between the front end and the output stage.
// ---------------------------------------------------------------------------
module ibsp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ibsp_pkg::t_result      i_data,
    input  logic                   i_pop,
    output logic                   o_full,
    output ibsp_pkg::t_queue_head  o_head
);
    import ibsp_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              w_do_pop;

    assign o_full        = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.data   = r_mem[r_rd_ptr];
    assign w_do_pop      = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = i_push   ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        case ({i_push, w_do_pop})
            2'b10:   n_count = r_count + (QPTR_W + 1)'(1);
            2'b01:   n_count = r_count - (QPTR_W + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/ibsp_emit.sv]
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - output stage
// Pops results, expands them into the output fields and holds them in the
// output register until taken.
// ---------------------------------------------------------------------------
module ibsp_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ibsp_pkg::t_queue_head              i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_kind,
    output logic [ibsp_pkg::TYPE_W-1:0]        o_data_type,
    output logic [ibsp_pkg::WORD_W-1:0]        o_payload_bytes,
    output logic [ibsp_pkg::WORD_W-1:0]        o_data_word,
    output logic                               o_last
);
    import ibsp_pkg::*;

    logic              r_valid;
    t_kind             r_kind;
    logic [TYPE_W-1:0] r_data_type;
    logic [WORD_W-1:0] r_payload_bytes;
    logic [WORD_W-1:0] r_data_word;
    logic              r_last;

    // Load a new result when the register is empty or being drained.
    assign o_pop = i_head.valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind          <= i_head.data.kind;
            r_data_type     <= i_head.data.data_type;
            r_last          <= i_head.data.last;
            r_payload_bytes <= (i_head.data.kind == KIND_HEADER) ? i_head.data.value : '0;
            r_data_word     <= (i_head.data.kind == KIND_PAYLOAD)
                             ? {i_head.data.value[7:0], i_head.data.value[15:8]} : '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_data_type     = r_data_type;
    assign o_payload_bytes = r_payload_bytes;
    assign o_data_word     = r_data_word;
    assign o_last          = r_last;

endmodule

[sv/iec61937_burst_sync_parser.sv]
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - top level
// Finds IEC 61937 burst preambles in a byte or subframe stream and reports
// headers, payload words and sync errors.
// ---------------------------------------------------------------------------
// The parser takes one sample per clock on the input channel (i_valid /
// o_ready) while o_ready is high and produces at most one result request per
// sample on the output channel (o_valid / i_ready). Sustained rate is one
// sample per cycle while the queue has room; the result of an accepted
// sample is written into the result queue and then loaded into the output
// register once that register is empty or being drained.
// o_ready drops only when the four-entry result queue is full, which happens
// only when the downstream side holds i_ready low. There is no clearing pass
// after reset. In byte mode (stream_mode = 0) words are formed little-endian
// from byte pairs, at any alignment while hunting and aligned to Pa after;
// in subframe mode the word is sample bits 27:12. Kinds: 0 header (type and
// length in bytes), 1 payload word (bytes swapped, last flags the end of the
// burst), 2 guard error (non-zero words just before Pa), 3 Pb mismatch.
// Write configuration only while idle; a stream_mode write restarts hunting.
// ---------------------------------------------------------------------------
module iec61937_burst_sync_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ibsp_pkg::SAMPLE_W-1:0]       i_sample,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_kind,
    output logic [ibsp_pkg::TYPE_W-1:0]         o_data_type,
    output logic [ibsp_pkg::WORD_W-1:0]         o_payload_bytes,
    output logic [ibsp_pkg::WORD_W-1:0]         o_data_word,
    output logic                                o_last,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [ibsp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ibsp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import ibsp_pkg::*;

    t_cfg        r_cfg;
    logic        w_mode_wr;
    logic        w_accept;
    logic        w_push;
    t_result     w_result;
    logic        w_full;
    logic        w_pop;
    t_queue_head w_head;

    // Configuration registers: each write lands in the low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stream_mode    <= 1'b0;
            r_cfg.sync_word_a    <= SYNC_A_RESET;
            r_cfg.sync_word_b    <= SYNC_B_RESET;
            r_cfg.bytes_len_type <= BYTES_TYPE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STREAM_MODE:    r_cfg.stream_mode    <= i_cfg_wdata[0];
                CFG_SYNC_WORD_A:    r_cfg.sync_word_a    <= i_cfg_wdata[WORD_W-1:0];
                CFG_SYNC_WORD_B:    r_cfg.sync_word_b    <= i_cfg_wdata[WORD_W-1:0];
                CFG_BYTES_LEN_TYPE: r_cfg.bytes_len_type <= i_cfg_wdata[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // A mode write drops any parse in progress and the counted history.
    assign w_mode_wr = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_STREAM_MODE);

    // Take a sample whenever the queue has room for its possible result.
    assign o_ready  = ~w_full;
    assign w_accept = i_valid && o_ready;

    ibsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_mode_wr(w_mode_wr),
        .i_accept (w_accept),
        .i_sample (i_sample),
        .o_push   (w_push),
        .o_result (w_result)
    );

    // Decouple the parser from output back-pressure.
    ibsp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_result),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_head (w_head)
    );

    ibsp_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_type    (o_data_type),
        .o_payload_bytes(o_payload_bytes),
        .o_data_word    (o_data_word),
        .o_last         (o_last)
    );

endmodule

[verif/iec61937_burst_sync_parser_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IEC 61937 burst sync parser - testbench
// Feeds byte and subframe streams built from well-formed bursts, broken
// preambles and noise under random stalls on both channels. A sample-level
// parse tracker predicts every report, and the monitor checks each returned
// report field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module iec61937_burst_sync_parser_tb;
    import ibsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 210;
    localparam int LONG_HOLD    = 200;

    typedef struct {
        t_kind             kind;
        logic [TYPE_W-1:0] data_type;
        logic [WORD_W-1:0] payload_bytes;
        logic [WORD_W-1:0] data_word;
        logic              last;
    } t_burst_report;

    // DUT connections; every input starts at a known value.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [1:0]            o_kind;
    logic [TYPE_W-1:0]     o_data_type;
    logic [WORD_W-1:0]     o_payload_bytes;
    logic [WORD_W-1:0]     o_data_word;
    logic                  o_last;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Samples waiting to be offered, and reports waiting to come back.
    logic [SAMPLE_W-1:0] pending_samples [$];
    t_burst_report       expected_reports [$];

    // Flow control knobs; idle rates and the long-hold request are set per phase by the stimulus process.
    int unsigned src_idle_pct = 20;
    int unsigned rx_idle_pct  = 20;
    int unsigned src_gap      = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_long_hold_req  = 1'b0;
    bit          rx_long_hold_seen = 1'b0;

    int unsigned failures    = 0;
    int unsigned cycle_count = 0;

    // Tracked register values.
    logic              cfg_mode;
    logic [WORD_W-1:0] cfg_sync_a;
    logic [WORD_W-1:0] cfg_sync_b;
    logic [TYPE_W-1:0] cfg_bytes_type;

    // Tracked parse state.
    t_phase            parse_phase;
    logic [7:0]        byte_hist [BYTE_DEPTH];
    logic [WORD_W-1:0] word_hist [WORD_HIST_DEPTH];
    int unsigned       hist_count;
    logic              pair_half;
    logic [TYPE_W-1:0] cur_type;
    logic [WORD_W-1:0] bytes_left;

    iec61937_burst_sync_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_type    (o_data_type),
        .o_payload_bytes(o_payload_bytes),
        .o_data_word    (o_data_word),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Guard words are the whole words right before Pa that are still held in
    // history; in byte mode they pair up aligned to Pa.
    function automatic bit guard_words_zero(input bit byte_mode);
        int unsigned avail;
        bit          clean;
        clean = 1'b1;
        if (byte_mode) begin
            avail = (hist_count >= 1) ? (hist_count - 1) / 2 : 0;
            if (avail > GUARD_WORDS) avail = GUARD_WORDS;
            for (int k = 1; k <= avail; k++) begin
                if (byte_hist[2*k] != 8'h00 || byte_hist[2*k-1] != 8'h00) clean = 1'b0;
            end
        end else begin
            avail = (hist_count > GUARD_WORDS) ? GUARD_WORDS : hist_count;
            for (int k = 0; k < avail; k++) begin
                if (word_hist[k] != '0) clean = 1'b0;
            end
        end
        return clean;
    endfunction

    // Advance the parse by one accepted sample and queue the report it causes.
    function automatic void track_burst_parse(input logic [SAMPLE_W-1:0] smp);
        t_burst_report     rep;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] len;
        logic [7:0]        b;
        bit                byte_mode;
        bit                have;
        bit                emit_rep;
        bit                back_mismatch;
        bit                back_clear;
        bit                fin;
        byte_mode     = !cfg_mode;
        b             = smp[7:0];
        w             = '0;
        have          = 1'b0;
        emit_rep      = 1'b0;
        back_mismatch = 1'b0;
        back_clear    = 1'b0;
        rep.kind          = KIND_HEADER;
        rep.data_type     = '0;
        rep.payload_bytes = '0;
        rep.data_word     = '0;
        rep.last          = 1'b0;

        // Form a word: any byte alignment while hunting, Pa-aligned pairs after.
        if (byte_mode) begin
            if (parse_phase == PH_HUNT) begin
                if (hist_count >= 1) begin
                    w    = {b, byte_hist[0]};
                    have = 1'b1;
                end
            end else if (pair_half) begin
                w         = {b, byte_hist[0]};
                have      = 1'b1;
                pair_half = 1'b0;
            end else begin
                pair_half = 1'b1;
            end
        end else begin
            w    = smp[SUBFRAME_LSB+WORD_W-1:SUBFRAME_LSB];
            have = 1'b1;
        end

        if (have) begin
            case (parse_phase)
                PH_HUNT: begin
                    if (w == cfg_sync_a) begin
                        if (guard_words_zero(byte_mode)) begin
                            parse_phase = PH_PB;
                            pair_half   = 1'b0;
                        end else begin
                            rep.kind = KIND_GUARD_ERR;
                            emit_rep = 1'b1;
                        end
                    end
                end
                PH_PB: begin
                    if (w == cfg_sync_b) begin
                        parse_phase = PH_PC;
                    end else begin
                        rep.kind      = KIND_PB_MISMATCH;
                        emit_rep      = 1'b1;
                        back_mismatch = 1'b1;
                    end
                end
                PH_PC: begin
                    cur_type    = w[TYPE_W-1:0];
                    parse_phase = PH_PD;
                end
                PH_PD: begin
                    // Pd counts bits except for the bytes-coded type.
                    len = (cur_type == cfg_bytes_type) ? w : {3'b000, w[WORD_W-1:3]};
                    rep.kind          = KIND_HEADER;
                    rep.data_type     = cur_type;
                    rep.payload_bytes = len;
                    emit_rep          = 1'b1;
                    if (len == '0) begin
                        back_clear = 1'b1;
                    end else begin
                        bytes_left  = len;
                        parse_phase = PH_PAY;
                    end
                end
                default: begin
                    fin        = (bytes_left <= 16'd2);
                    bytes_left = fin ? '0 : bytes_left - 16'd2;
                    rep.kind      = KIND_PAYLOAD;
                    rep.data_type = cur_type;
                    rep.data_word = {w[7:0], w[15:8]};
                    rep.last      = fin;
                    emit_rep      = 1'b1;
                    if (fin) back_clear = 1'b1;
                end
            endcase
        end

        // Shift the history of the active mode.
        if (byte_mode) begin
            for (int i = BYTE_DEPTH - 1; i > 0; i--) byte_hist[i] = byte_hist[i-1];
            byte_hist[0] = b;
            if (hist_count < BYTE_DEPTH) hist_count++;
        end else begin
            for (int i = WORD_HIST_DEPTH - 1; i > 0; i--) word_hist[i] = word_hist[i-1];
            word_hist[0] = w;
            if (hist_count < GUARD_WORDS) hist_count++;
        end

        // A rejected Pb keeps its high byte as history in byte mode only.
        if (back_mismatch) begin
            parse_phase = PH_HUNT;
            pair_half   = 1'b0;
            hist_count  = byte_mode ? 1 : 0;
        end else if (back_clear) begin
            parse_phase = PH_HUNT;
            pair_half   = 1'b0;
            hist_count  = 0;
        end

        if (emit_rep) expected_reports.push_back(rep);
    endfunction

    function automatic void store_config(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_STREAM_MODE: begin
                // Any mode write restarts hunting with nothing counted.
                cfg_mode    = val[0];
                parse_phase = PH_HUNT;
                hist_count  = 0;
                pair_half   = 1'b0;
            end
            CFG_SYNC_WORD_A:    cfg_sync_a     = val;
            CFG_SYNC_WORD_B:    cfg_sync_b     = val;
            CFG_BYTES_LEN_TYPE: cfg_bytes_type = val[TYPE_W-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        logic [31:0] rnd;
        rnd = $urandom();
        pending_samples.push_back({rnd[31:8], b});
    endtask

    // Queue one 16-bit stream word in the framing of the current mode; the
    // unused sample bits carry random junk.
    task automatic push_word(input logic [WORD_W-1:0] w);
        logic [31:0] rnd;
        rnd = $urandom();
        if (!cfg_mode) begin
            push_byte(w[7:0]);
            push_byte(w[15:8]);
        end else begin
            pending_samples.push_back({rnd[31:28], w, rnd[11:0]});
        end
    endtask

    // Queue one burst, mostly well formed, sometimes noise, a dirty guard,
    // a bad Pb or a stream that stops right after Pa.
    task automatic push_burst();
        int unsigned       r;
        int unsigned       n_guard;
        logic [31:0]       rnd;
        logic [TYPE_W-1:0] ftype;
        logic [WORD_W-1:0] len_b;
        logic [WORD_W-1:0] pd;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 6)) pending_samples.push_back($urandom());
            return;
        end
        // Shift the byte alignment now and then.
        if (!cfg_mode && $urandom_range(0, 1) == 1) pending_samples.push_back($urandom());
        n_guard = $urandom_range(0, GUARD_WORDS + 1);
        repeat (n_guard) push_word('0);
        if (r < 22) begin
            rnd = $urandom_range(1, 65535);
            push_word(rnd[15:0]);
        end
        push_word(cfg_sync_a);
        if (r < 30) begin
            if (r < 26) begin
                rnd = $urandom_range(1, 65535);
                push_word(cfg_sync_b ^ rnd[15:0]);
            end
            return;
        end
        push_word(cfg_sync_b);
        if ($urandom_range(0, 2) == 0) begin
            ftype = cfg_bytes_type;
        end else begin
            rnd   = $urandom();
            ftype = rnd[TYPE_W-1:0];
        end
        rnd = $urandom();
        push_word({rnd[15:5], ftype});
        r = $urandom_range(0, 99);
        if (r < 8)       rnd = 0;
        else if (r < 75) rnd = $urandom_range(1, 24);
        else             rnd = $urandom_range(25, 120);
        len_b = rnd[15:0];
        rnd   = $urandom();
        pd    = (ftype == cfg_bytes_type) ? len_b : {len_b[12:0], rnd[2:0]};
        push_word(pd);
        for (int unsigned k = 0; k < (len_b + 1) / 2; k++) begin
            rnd = $urandom();
            push_word(($urandom_range(0, 9) == 0) ? cfg_sync_a : rnd[15:0]);
        end
    endtask

    // Block until every request went in, every report came back and the
    // pipeline had time to settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_valid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        store_config(idx, val);
    endtask

    // Write all four registers; narrow ones get random junk above their width.
    task automatic set_config(input logic mode, input logic [WORD_W-1:0] pa,
                              input logic [WORD_W-1:0] pb, input logic [TYPE_W-1:0] btype);
        logic [31:0] rnd;
        rnd = $urandom();
        write_reg(CFG_STREAM_MODE, {rnd[15:1], mode});
        write_reg(CFG_SYNC_WORD_A, pa);
        write_reg(CFG_SYNC_WORD_B, pb);
        write_reg(CFG_BYTES_LEN_TYPE, {rnd[26:16], btype});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Sender: offer queued samples, hold each request until accepted, and
    // insert random idle bursts between requests.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : sample_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) track_burst_parse(i_sample);
            if (i_valid && !o_ready) begin
                // Hold the request and its payload.
            end else if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (pending_samples.size() != 0 && src_idle_pct != 0 &&
                         $urandom_range(0, 99) < src_idle_pct) begin
                src_gap = $urandom_range(0, 11);
                i_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                i_valid  <= 1'b1;
                i_sample <= pending_samples.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: check each accepted report against the oldest prediction,
    // then pick the next ready level (random stalls, one long hold).
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_burst_report exp_rep;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: kind %0d data_word %h", o_kind, o_data_word);
                    failures++;
                end else begin
                    exp_rep = expected_reports.pop_front();
                    if (o_kind !== exp_rep.kind) begin
                        $error("kind: expected %0d, actual %0d", exp_rep.kind, o_kind);
                        failures++;
                    end
                    if (o_data_type !== exp_rep.data_type) begin
                        $error("data_type: expected %0d, actual %0d",
                               exp_rep.data_type, o_data_type);
                        failures++;
                    end
                    if (o_payload_bytes !== exp_rep.payload_bytes) begin
                        $error("payload_bytes: expected %0d, actual %0d",
                               exp_rep.payload_bytes, o_payload_bytes);
                        failures++;
                    end
                    if (o_data_word !== exp_rep.data_word) begin
                        $error("data_word: expected %h, actual %h", exp_rep.data_word, o_data_word);
                        failures++;
                    end
                    if (o_last !== exp_rep.last) begin
                        $error("last: expected %0d, actual %0d", exp_rep.last, o_last);
                        failures++;
                    end
                end
            end
            if (rx_long_hold_req && !rx_long_hold_seen) begin
                rx_long_hold_seen = 1'b1;
                rx_hold_left      = LONG_HOLD;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap = $urandom_range(0, 11);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] rnd;
        logic [31:0] rnd2;
        // Tracked state after reset.
        cfg_mode       = 1'b0;
        cfg_sync_a     = SYNC_A_RESET;
        cfg_sync_b     = SYNC_B_RESET;
        cfg_bytes_type = BYTES_TYPE_RESET;
        parse_phase    = PH_HUNT;
        hist_count     = 0;
        pair_half      = 1'b0;
        cur_type       = '0;
        bytes_left     = '0;
        foreach (byte_hist[i]) byte_hist[i] = 8'h00;
        foreach (word_hist[i]) word_hist[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Byte mode at stream start with reset registers: Pa at odd
        // alignment, a bad Pb whose high byte starts the next Pa, then a
        // one-byte burst of the bytes-coded type.
        push_byte(8'h01);
        push_word(16'hF872);
        push_word(16'h7200);
        push_byte(8'hF8);
        push_word(16'h4E1F);
        push_word(16'hFFF5);
        push_word(16'h0001);
        push_word(16'hCDAB);
        wait_drained();

        // Subframe mode: zero-length burst, then the largest byte length,
        // which the next mode write cuts off.
        set_config(1'b1, SYNC_A_RESET, SYNC_B_RESET, BYTES_TYPE_RESET);
        push_word(SYNC_A_RESET);
        push_word(SYNC_B_RESET);
        push_word(16'hFFF5);
        push_word(16'h0000);
        push_word(SYNC_A_RESET);
        push_word(SYNC_B_RESET);
        push_word(16'h0015);
        push_word(16'hFFFF);
        wait_drained();

        // Bit-coded length with an odd byte count, a bad Pb, then a dirty
        // guard word in front of Pa.
        set_config(1'b1, SYNC_A_RESET, SYNC_B_RESET, 5'd31);
        push_word(SYNC_A_RESET);
        push_word(SYNC_B_RESET);
        push_word(16'h0015);
        push_word(16'h001F);
        push_word(16'hFFFF);
        push_word(16'h0000);
        push_word(SYNC_A_RESET);
        push_word(16'h4E1E);
        push_word(16'hFFFF);
        push_word(SYNC_A_RESET);

        // Random phases, each at its own register setting.
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            rnd  = $urandom();
            rnd2 = $urandom();
            case (p)
                0: set_config(1'b0, SYNC_A_RESET, SYNC_B_RESET, BYTES_TYPE_RESET);
                1: set_config(1'b1, SYNC_A_RESET, SYNC_B_RESET, BYTES_TYPE_RESET);
                2: set_config(1'b0, 16'hFFFF, 16'h0000, 5'd0);
                3: set_config(1'b1, 16'h0000, 16'hFFFF, 5'd31);
                default: set_config(rnd2[p % 2], rnd[15:0], rnd[31:16], rnd2[12:8]);
            endcase
            if (p == 7) begin
                // Let the last phase stream with no idling on either side.
                src_idle_pct = 0;
                rx_idle_pct  = 0;
            end else if (p == 1) begin
                src_idle_pct = 5;
                rx_idle_pct  = $urandom_range(0, 30);
            end else begin
                src_idle_pct = $urandom_range(0, 30);
                rx_idle_pct  = $urandom_range(0, 30);
            end
            while (pending_samples.size() < PHASE_ITEMS) push_burst();
            // Stall the receiver for a long stretch so the result queue
            // fills and the input side backs up.
            if (p == 1) rx_long_hold_req = 1'b1;
        end
        wait_drained();

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[iec61937_burst_sync_parser.f]
+incdir+sv
sv/ibsp_pkg.sv
sv/ibsp_front.sv
sv/ibsp_queue.sv
sv/ibsp_emit.sv
sv/iec61937_burst_sync_parser.sv
verif/iec61937_burst_sync_parser_tb.sv
